// ===== rtl/imh_pkg.sv =====
// Package for the indexed max-heap: sizes, codes, controller states and the
// command/status structs that join the controller and datapath. No dependencies.
package imh_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 16;
    localparam int LABEL_BITS = 6;
    localparam int POS_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int LABEL_COUNT = 1 << LABEL_BITS;

    typedef logic [LABEL_BITS-1:0] label_t;
    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [POS_BITS-1:0]   pos_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;

    typedef struct packed {
        label_t lbl;
        key_t   key;
    } entry_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_PRESENT = 2'd3
    } status_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD_HOLE,
        S_RD_LAST,
        S_FILL,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_RD2,
        S_DN_CMP,
        S_DONE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;     // latch the input word
        logic wr_append;   // write new entry at slot count, map it, count++
        logic rd_hole;     // read the entry at the hole
        logic rd_last;     // read slot count-1, unmark the label, count--
        logic fill_hole;   // write the moving entry into the hole and map it
        logic rd_parent;   // read parent of cursor
        logic up_swap;     // swap cursor with parent
        logic rd_left;     // read left child
        logic rd_right;    // read right child
        logic dn_swap;     // swap cursor with chosen child
        logic set_status;  // latch computed status code
        logic strobe;      // present result
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic    is_remove;
        status_t chk;        // result of the presence/full test
        logic    hole_last;  // hole is the last slot
        logic    at_root;
        logic    up_go;      // parent strictly smaller
        logic    has_left;
        logic    dn_go;      // chosen child strictly greater
        logic    moved_up;   // the filled hole rose at least once
    } stat_t;

endpackage

// ===== rtl/imh_ctrl.sv =====
// Controller state machine for the indexed max-heap.
// Depends on imh_pkg.
module imh_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  imh_pkg::stat_t st,
    output imh_pkg::cmd_t  cmd
);
    import imh_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (start) state_next = S_CHECK;
            S_CHECK:
            begin
                if (st.chk != ST_OK)       state_next = S_DONE;
                else if (st.is_remove)     state_next = S_RD_HOLE;
                else                       state_next = S_UP_RD;
            end
            S_RD_HOLE: state_next = S_RD_LAST;
            S_RD_LAST: state_next = st.hole_last ? S_DONE : S_FILL;
            S_FILL:    state_next = S_UP_RD;
            S_UP_RD:
            begin
                if (!st.at_root)                       state_next = S_UP_CMP;
                else if (st.is_remove && !st.moved_up) state_next = S_DN_RD;
                else                                   state_next = S_DONE;
            end
            S_UP_CMP:
            begin
                if (st.up_go)                          state_next = S_UP_RD;
                else if (st.is_remove && !st.moved_up) state_next = S_DN_RD;
                else                                   state_next = S_DONE;
            end
            S_DN_RD:   state_next = st.has_left ? S_DN_RD2 : S_DONE;
            S_DN_RD2:  state_next = S_DN_CMP;
            S_DN_CMP:  state_next = st.dn_go ? S_DN_RD : S_DONE;
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:    cmd.capture = start;
            S_CHECK:
            begin
                cmd.set_status = 1'b1;
                cmd.wr_append  = (st.chk == ST_OK) && !st.is_remove;
            end
            S_RD_HOLE: cmd.rd_hole = 1'b1;
            S_RD_LAST: cmd.rd_last = 1'b1;
            S_FILL:    cmd.fill_hole = 1'b1;
            S_UP_RD:   cmd.rd_parent = 1'b1;
            S_UP_CMP:  cmd.up_swap = st.up_go;
            S_DN_RD:   cmd.rd_left = 1'b1;
            S_DN_RD2:  cmd.rd_right = 1'b1;
            S_DN_CMP:  cmd.dn_swap = st.dn_go;
            S_DONE:    cmd.strobe = 1'b1;
            default:   cmd = '0;
        endcase
    end

    a_strobe_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.strobe |=> state_reg == S_IDLE)
        else $error("strobe not followed by idle");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == S_CHECK)
        else $error("accepted word did not enter check");
    a_swap_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.up_swap && cmd.dn_swap))
        else $error("both swaps in one cycle");

endmodule

// ===== rtl/imh_dp.sv =====
// Datapath of the indexed max-heap: heap memory, position map, count,
// cursor and result registers. Depends on imh_pkg.
module imh_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 op,
    input  imh_pkg::label_t      label,
    input  imh_pkg::key_t        height,
    input  imh_pkg::cmd_t        cmd,
    output imh_pkg::stat_t       st,
    output logic [1:0]           status,
    output imh_pkg::label_t      removed_label,
    output imh_pkg::key_t        removed_height,
    output imh_pkg::label_t      top_label,
    output imh_pkg::key_t        top_height,
    output logic                 is_empty,
    output imh_pkg::cnt_t        entry_count
);
    import imh_pkg::*;

    // Heap store memory, read through registers; a read of a slot that holds no
    // entry can occur, but its data is then not used.
    entry_t heap_mem [CAPACITY];
    // Position map with per-label valid bits.
    pos_t   pmap_reg [LABEL_COUNT];
    logic [LABEL_COUNT-1:0] pres_reg;

    cnt_t    cnt_reg;
    logic    op_reg;
    label_t  lbl_reg;
    key_t    key_reg;
    status_t status_reg;
    pos_t    cur_reg;      // position of the moving entry
    entry_t  cur_e_reg;    // the moving entry
    entry_t  oth_reg;      // parent or left child read
    entry_t  rgt_reg;      // right child read
    entry_t  rem_reg;
    entry_t  top_reg;      // copy of slot 0, kept on every write there
    logic    moved_reg;

    pos_t   par_pos, left_pos, right_pos, pick_pos, last_pos;
    logic   [POS_BITS:0] left_w;
    entry_t pick_e;
    logic   left_ok, right_ok, pick_left;
    status_t chk;

    assign last_pos  = pos_t'(cnt_reg - cnt_t'(1));
    assign par_pos   = pos_t'((cur_reg - pos_t'(1)) >> 1);
    assign left_w    = {cur_reg, 1'b1};
    assign left_pos  = left_w[POS_BITS-1:0];
    assign right_pos = pos_t'(left_pos + pos_t'(1));
    assign left_ok   = CNT_BITS'(left_w) < cnt_reg;
    assign right_ok  = (CNT_BITS'(left_w) + cnt_t'(1)) < cnt_reg;
    assign pick_left = !right_ok || (oth_reg.key > rgt_reg.key);
    assign pick_pos  = pick_left ? left_pos : right_pos;
    assign pick_e    = pick_left ? oth_reg : rgt_reg;

    always_comb
    begin
        if (op_reg == OP_INSERT)
        begin
            if (pres_reg[lbl_reg])                  chk = ST_PRESENT;
            else if (cnt_reg >= cnt_t'(CAPACITY))   chk = ST_FULL;
            else                                    chk = ST_OK;
        end
        else
        begin
            chk = pres_reg[lbl_reg] ? ST_OK : ST_ABSENT;
        end
    end

    assign st.is_remove = op_reg;
    assign st.chk       = chk;
    assign st.hole_last = (cur_reg == last_pos);
    assign st.at_root   = (cur_reg == '0);
    assign st.up_go     = oth_reg.key < cur_e_reg.key;
    assign st.has_left  = left_ok;
    assign st.dn_go     = pick_e.key > cur_e_reg.key;
    assign st.moved_up  = moved_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            lbl_reg <= label;
            key_reg <= height;
        end
        if (cmd.wr_append)
        begin
            heap_mem[pos_t'(cnt_reg)] <= '{lbl: lbl_reg, key: key_reg};
            if (cnt_reg == '0)
            begin
                top_reg <= '{lbl: lbl_reg, key: key_reg};
            end
        end
        if (cmd.set_status)
        begin
            // A remove starts at the mapped slot of its label.
            cur_reg   <= (op_reg == OP_REMOVE) ? pmap_reg[lbl_reg] : pos_t'(cnt_reg);
            cur_e_reg <= '{lbl: lbl_reg, key: key_reg};
            moved_reg <= 1'b0;
            rem_reg   <= '0;
        end
        if (cmd.rd_hole)
        begin
            rem_reg <= heap_mem[cur_reg];
        end
        if (cmd.rd_last)
        begin
            cur_e_reg <= heap_mem[last_pos];
        end
        if (cmd.fill_hole)
        begin
            heap_mem[cur_reg] <= cur_e_reg;
            if (cur_reg == '0)
            begin
                top_reg <= cur_e_reg;
            end
        end
        if (cmd.rd_parent)
        begin
            oth_reg <= heap_mem[par_pos];
        end
        if (cmd.up_swap)
        begin
            heap_mem[par_pos] <= cur_e_reg;
            heap_mem[cur_reg] <= oth_reg;
            if (par_pos == '0)
            begin
                top_reg <= cur_e_reg;
            end
            cur_reg   <= par_pos;
            moved_reg <= 1'b1;
        end
        if (cmd.rd_left)
        begin
            oth_reg <= heap_mem[left_pos];
        end
        if (cmd.rd_right)
        begin
            rgt_reg <= heap_mem[right_pos];
        end
        if (cmd.dn_swap)
        begin
            heap_mem[pick_pos] <= cur_e_reg;
            heap_mem[cur_reg]  <= pick_e;
            if (cur_reg == '0)
            begin
                top_reg <= pick_e;
            end
            cur_reg <= pick_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_append)
        begin
            pmap_reg[lbl_reg] <= pos_t'(cnt_reg);
        end
        if (cmd.fill_hole)
        begin
            pmap_reg[cur_e_reg.lbl] <= cur_reg;
        end
        if (cmd.up_swap)
        begin
            pmap_reg[cur_e_reg.lbl] <= par_pos;
            pmap_reg[oth_reg.lbl]   <= cur_reg;
        end
        if (cmd.dn_swap)
        begin
            pmap_reg[cur_e_reg.lbl] <= pick_pos;
            pmap_reg[pick_e.lbl]    <= cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pres_reg   <= '0;
            cnt_reg    <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (cmd.set_status)
            begin
                status_reg <= chk;
            end
            if (cmd.wr_append)
            begin
                pres_reg[lbl_reg] <= 1'b1;
                cnt_reg <= cnt_t'(cnt_reg + cnt_t'(1));
            end
            if (cmd.rd_last)
            begin
                pres_reg[lbl_reg] <= 1'b0;
                cnt_reg <= cnt_t'(cnt_reg - cnt_t'(1));
            end
        end
    end

    assign status         = status_reg;
    assign removed_label  = rem_reg.lbl;
    assign removed_height = rem_reg.key;
    assign is_empty       = (cnt_reg == '0);
    assign top_label      = is_empty ? '0 : top_reg.lbl;
    assign top_height     = is_empty ? '0 : top_reg.key;
    assign entry_count    = cnt_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= cnt_t'(CAPACITY))
        else $error("count above capacity");
    a_append_marks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_append |=> pres_reg[$past(lbl_reg)])
        else $error("inserted label not present");
    a_remove_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_hole |=> !pres_reg[$past(lbl_reg)])
        else $error("removed label still present");

endmodule

// ===== rtl/indexed_max_heap_top.sv =====
// Top level of the indexed max-heap priority queue.
// Depends on imh_pkg, imh_ctrl and imh_dp.
//
// Pulse start with a word (op, label, height) while busy is low; the word is
// taken at that edge, busy rises, and when the operation ends the result word
// is shown for exactly one cycle with done high. The receiver cannot stall, so
// the result must be taken in that cycle. A rejected word (label present,
// heap full, label absent) goes from the check straight to the result. An
// insert appends the entry and lets it climb; a remove of the last slot ends
// once that slot is read; any other remove fills the hole with the last entry,
// which climbs or, if it did not rise, sinks, at most five levels from the
// root. The time is set by one registered heap read per step of the sift
// loop. The top entry, empty flag and count reflect the heap after the
// operation.
module indexed_max_heap_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 op,
    input  imh_pkg::label_t      label,
    input  imh_pkg::key_t        height,
    output logic                 done,
    output logic [1:0]           status,
    output imh_pkg::label_t      removed_label,
    output imh_pkg::key_t        removed_height,
    output imh_pkg::label_t      top_label,
    output imh_pkg::key_t        top_height,
    output logic                 is_empty,
    output imh_pkg::cnt_t        entry_count
);
    import imh_pkg::*;

    cmd_t  cmd;
    stat_t st;

    imh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .cmd   (cmd)
    );

    imh_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .label          (label),
        .height         (height),
        .cmd            (cmd),
        .st             (st),
        .status         (status),
        .removed_label  (removed_label),
        .removed_height (removed_height),
        .top_label      (top_label),
        .top_height     (top_height),
        .is_empty       (is_empty),
        .entry_count    (entry_count)
    );

    assign done = cmd.strobe;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result outside an operation");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the indexed max-heap priority queue.
// Depends on imh_pkg and indexed_max_heap_top; a built-in heap predictor
// checks every result word against the expected top, count and status.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import imh_pkg::*;

    typedef struct {
        logic   op;
        label_t lbl;
        key_t   hgt;
    } cmd_word_t;

    typedef struct {
        status_t st;
        label_t  rem_lbl;
        key_t    rem_hgt;
        label_t  top_lbl;
        key_t    top_hgt;
        logic    empty;
        cnt_t    cnt;
    } heap_view_t;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic            op;
    label_t          label;
    key_t            height;
    logic            done;
    logic [1:0]      status;
    label_t          removed_label;
    key_t            removed_height;
    label_t          top_label;
    key_t            top_height;
    logic            is_empty;
    cnt_t            entry_count;

    indexed_max_heap_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .label          (label),
        .height         (height),
        .done           (done),
        .status         (status),
        .removed_label  (removed_label),
        .removed_height (removed_height),
        .top_label      (top_label),
        .top_height     (top_height),
        .is_empty       (is_empty),
        .entry_count    (entry_count)
    );

    // Predictor state: a mirror of the heap, its label map and its fill count.
    label_t     mirror_lbl [CAPACITY];
    key_t       mirror_hgt [CAPACITY];
    int         slot_of    [LABEL_COUNT];
    bit         held       [LABEL_COUNT];
    int         held_count;

    cmd_word_t  pending_words[$];
    heap_view_t expected_views[$];
    int         fail_count;
    int         idle_pct;
    bit         hold_off;
    bit         stim_done;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Generous time limit for every word and idle gap, many times over.
    initial
    begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

    function automatic void mirror_set(int pos, label_t l, key_t h);
        mirror_lbl[pos] = l;
        mirror_hgt[pos] = h;
        slot_of[l]      = pos;
    endfunction

    function automatic void mirror_swap(int a, int b);
        label_t la;
        key_t   ha;
        la = mirror_lbl[a];
        ha = mirror_hgt[a];
        mirror_set(a, mirror_lbl[b], mirror_hgt[b]);
        mirror_set(b, la, ha);
    endfunction

    function automatic int mirror_climb(int pos);
        int par;
        while (pos > 0)
        begin
            par = (pos - 1) / 2;
            if (mirror_hgt[par] < mirror_hgt[pos])
            begin
                mirror_swap(par, pos);
                pos = par;
            end
            else
                break;
        end
        return pos;
    endfunction

    // Ties go to the right child; a move needs a strictly greater child.
    function automatic void mirror_sink(int pos);
        int lft;
        int pick;
        forever
        begin
            lft = 2 * pos + 1;
            if (lft >= held_count)
                break;
            pick = lft;
            if (lft + 1 < held_count && !(mirror_hgt[lft] > mirror_hgt[lft + 1]))
                pick = lft + 1;
            if (mirror_hgt[pick] > mirror_hgt[pos])
            begin
                mirror_swap(pick, pos);
                pos = pick;
            end
            else
                break;
        end
    endfunction

    function automatic heap_view_t apply_heap_word(cmd_word_t w);
        heap_view_t v;
        int hole;
        int last;
        v = '{st: ST_OK, rem_lbl: '0, rem_hgt: '0, top_lbl: '0, top_hgt: '0,
              empty: 1'b0, cnt: '0};
        if (w.op == OP_INSERT)
        begin
            // The duplicate test comes before the full test.
            if (held[w.lbl])
                v.st = ST_PRESENT;
            else if (held_count >= CAPACITY)
                v.st = ST_FULL;
            else
            begin
                mirror_set(held_count, w.lbl, w.hgt);
                held[w.lbl] = 1'b1;
                held_count++;
                void'(mirror_climb(held_count - 1));
            end
        end
        else if (!held[w.lbl])
            v.st = ST_ABSENT;
        else
        begin
            hole = slot_of[w.lbl];
            last = held_count - 1;
            v.rem_lbl = mirror_lbl[hole];
            v.rem_hgt = mirror_hgt[hole];
            held[w.lbl] = 1'b0;
            held_count = last;
            if (hole != last)
            begin
                // The moved entry rises if it can, otherwise it sinks.
                mirror_set(hole, mirror_lbl[last], mirror_hgt[last]);
                if (mirror_climb(hole) == hole)
                    mirror_sink(hole);
            end
        end
        if (held_count > 0)
        begin
            v.top_lbl = mirror_lbl[0];
            v.top_hgt = mirror_hgt[0];
        end
        v.empty = (held_count == 0);
        v.cnt   = cnt_t'(held_count);
        return v;
    endfunction

    // Driver: one word per handshake, idle gaps drawn per cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start  <= 1'b0;
            op     <= OP_INSERT;
            label  <= '0;
            height <= '0;
        end
        else if (start && !busy)
        begin
            // The word is taken at this edge: predict it now.
            expected_views = {expected_views,
                              apply_heap_word(cmd_word_t'{op, label, height})};
            void'(pending_words.pop_front());
            if (pending_words.size() > 0 && !hold_off &&
                $urandom_range(99) >= idle_pct)
            begin
                op     <= pending_words[0].op;
                label  <= pending_words[0].lbl;
                height <= pending_words[0].hgt;
            end
            else
                start <= 1'b0;
        end
        else if (!start && pending_words.size() > 0 && !hold_off &&
                 $urandom_range(99) >= idle_pct)
        begin
            start  <= 1'b1;
            op     <= pending_words[0].op;
            label  <= pending_words[0].lbl;
            height <= pending_words[0].hgt;
        end
    end

    // Monitor: every done cycle carries one result word.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_views.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                heap_view_t e;
                e = expected_views.pop_front();
                if (status !== e.st)
                begin
                    $error("status: expected %0d actual %0d", e.st, status);
                    fail_count++;
                end
                if (removed_label !== e.rem_lbl)
                begin
                    $error("removed_label: expected %0d actual %0d", e.rem_lbl,
                           removed_label);
                    fail_count++;
                end
                if (removed_height !== e.rem_hgt)
                begin
                    $error("removed_height: expected %0d actual %0d", e.rem_hgt,
                           removed_height);
                    fail_count++;
                end
                if (top_label !== e.top_lbl)
                begin
                    $error("top_label: expected %0d actual %0d", e.top_lbl, top_label);
                    fail_count++;
                end
                if (top_height !== e.top_hgt)
                begin
                    $error("top_height: expected %0d actual %0d", e.top_hgt,
                           top_height);
                    fail_count++;
                end
                if (is_empty !== e.empty)
                begin
                    $error("is_empty: expected %0d actual %0d", e.empty, is_empty);
                    fail_count++;
                end
                if (entry_count !== e.cnt)
                begin
                    $error("entry_count: expected %0d actual %0d", e.cnt,
                           entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus only needs to know which labels it believes are held, so that
    // most removes hit a present label and most inserts a fresh one.
    bit gen_held[LABEL_COUNT];
    int gen_count;

    task automatic queue_word(logic o, label_t l, key_t h);
        pending_words = {pending_words, cmd_word_t'{o, l, h}};
        if (o == OP_INSERT && !gen_held[l] && gen_count < CAPACITY)
        begin
            gen_held[l] = 1'b1;
            gen_count++;
        end
        else if (o == OP_REMOVE && gen_held[l])
        begin
            gen_held[l] = 1'b0;
            gen_count--;
        end
    endtask

    function automatic label_t pick_held();
        label_t l;
        l = label_t'($urandom);
        while (!gen_held[l])
            l++;
        return l;
    endfunction

    task automatic queue_random(int n);
        int     r;
        label_t l;
        key_t   h;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            l = label_t'($urandom);
            // Heights come from a narrow range often so that ties are common.
            h = ($urandom_range(2) == 0) ? key_t'($urandom_range(3)) : key_t'($urandom);
            if (gen_count > 0 && (r < 40 || (gen_count > 56 && r < 70)))
                queue_word(OP_REMOVE, pick_held(), key_t'($urandom));
            else if (r < 92)
                queue_word(OP_INSERT, l, h);
            else
                queue_word(logic'($urandom_range(1)), l, h);
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || expected_views.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < LABEL_COUNT; i++)
        begin
            held[i]     = 1'b0;
            slot_of[i]  = 0;
            gen_held[i] = 1'b0;
        end
        held_count = 0;
        gen_count  = 0;
        fail_count = 0;
        idle_pct   = 0;
        hold_off   = 1'b0;
        stim_done  = 1'b0;
        rst_n      = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty remove, extremes, ties, duplicate and absent cases.
        queue_word(OP_REMOVE, 6'd0, 16'hFFFF);
        queue_word(OP_INSERT, 6'd63, 16'hFFFF);
        queue_word(OP_INSERT, 6'd0, 16'h0000);
        queue_word(OP_INSERT, 6'd63, 16'h1234);
        queue_word(OP_INSERT, 6'd21, 16'hFFFF);
        queue_word(OP_INSERT, 6'd42, 16'h5555);
        queue_word(OP_INSERT, 6'd7, 16'hAAAA);
        queue_word(OP_INSERT, 6'd8, 16'h0000);
        queue_word(OP_REMOVE, 6'd0, 16'h0000);
        queue_word(OP_REMOVE, 6'd63, 16'h0000);
        queue_word(OP_REMOVE, 6'd63, 16'h0000);
        queue_word(OP_REMOVE, 6'd21, 16'h0000);
        queue_word(OP_REMOVE, 6'd42, 16'h0000);
        queue_word(OP_REMOVE, 6'd7, 16'h0000);
        queue_word(OP_REMOVE, 6'd8, 16'h0000);
        wait_drained();

        // Fill to capacity, overflow, remove and re-insert one label, then drain all labels in scrambled order.
        for (int i = 0; i < CAPACITY; i++)
            queue_word(OP_INSERT, label_t'(i), key_t'($urandom_range(7)));
        queue_word(OP_INSERT, 6'd5, 16'h0001);
        queue_word(OP_REMOVE, 6'd9, 16'h0000);
        queue_word(OP_INSERT, 6'd9, 16'h0000);
        queue_word(OP_INSERT, 6'd9, 16'h0000);
        for (int i = 0; i < CAPACITY; i++)
            queue_word(OP_REMOVE, label_t'(i ^ 6'h2A), 16'h0000);

        // Random phases with different idling; stimulus is held off after the first drain.
        queue_random(150);
        wait_drained();
        hold_off = 1'b1;
        repeat (5) @(posedge clk);
        hold_off = 1'b0;
        idle_pct = 54;
        queue_random(150);
        wait_drained();
        idle_pct = 20;
        queue_random(150);
        wait_drained();
        idle_pct = 0;
        queue_random(100);
        wait_drained();
        repeat (40) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
